// ===== hdl/lwi_pkg.sv =====
// ----------------------------------------------------------------------------
// lwi_pkg: shared types and constants of the Lagrange window interpolator
// Table geometry, request and status codes, sequencer states, unit control.
// ----------------------------------------------------------------------------
package lwi_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int TIME_W     = 40;
	localparam int POS_W      = 48;
	localparam int ORD_W      = 4;
	localparam logic [ORD_W-1:0] MAX_ORDER = 4'd15;
	localparam logic [ORD_W-1:0] ORDER_RST = 4'd8;
	localparam int MAG_W      = 63;
	localparam int PROD_W     = MAG_W + POS_W;
	localparam int ACC_W      = 128;
	localparam logic [MAG_W-1:0] W_ONE = 63'h1 << 32;
	localparam logic [MAG_W-1:0] W_MAX = 63'h1 << 62;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FEW   = 2'd1,
		ST_FULL  = 2'd2,
		ST_ORDER = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_FIRST_W, S_BS, S_BS_W, S_START, S_K, S_K_W,
		S_I, S_I_W, S_MUL, S_DIV, S_PROD, S_PMUL, S_FIN, S_DONE
	} state_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_ctl_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
	} entry_t;

endpackage

// ===== hdl/lwi_if.sv =====
// ----------------------------------------------------------------------------
// lwi interfaces: request, result and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lwi_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [39:0]        sample_time;
	logic signed [47:0] sample_x;
	logic signed [47:0] sample_y;
	logic signed [47:0] sample_z;
	modport source (output valid, req_type, sample_time, sample_x, sample_y, sample_z,
		input ready);
	modport sink (input valid, req_type, sample_time, sample_x, sample_y, sample_z,
		output ready);
endinterface

interface lwi_res_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic signed [47:0] pos_z;
	logic [1:0]         status;
	modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

interface lwi_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/lwi_store.sv =====
// ----------------------------------------------------------------------------
// lwi_store: sample table memory
// One write port and one registered read port over time and position words.
// ----------------------------------------------------------------------------
module lwi_store (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [lwi_pkg::ADDR_W-1:0] wr_addr,
	input  lwi_pkg::entry_t        wr_data,
	input  logic                   rd_en,
	input  logic [lwi_pkg::ADDR_W-1:0] rd_addr,
	output lwi_pkg::entry_t        rd_data
);
	import lwi_pkg::*;

	entry_t mem [MAX_POINTS];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

// ===== hdl/lwi_alu.sv =====
// ----------------------------------------------------------------------------
// lwi_alu: shared shift-add multiplier and restoring divider
// Multiply takes 48 steps; divide reuses the product and takes 64 steps.
// ----------------------------------------------------------------------------
module lwi_alu (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lwi_pkg::alu_ctl_t       ctl,
	input  logic [lwi_pkg::MAG_W-1:0]  a,
	input  logic [lwi_pkg::POS_W-1:0]  b,
	input  logic [lwi_pkg::TIME_W-1:0] den,
	output logic                    done,
	output logic [lwi_pkg::PROD_W-1:0] prod
);
	import lwi_pkg::*;

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [5:0]        cnt_q;
	logic [PROD_W-1:0] p_q;
	logic [MAG_W-1:0]  a_q;
	logic [TIME_W-1:0] den_q;
	logic [TIME_W-1:0] rem_q;
	logic [MAG_W:0]    sum;
	logic [TIME_W:0]   rem2;
	logic              ge;
	logic [5:0]        last;

	assign sum  = {1'b0, p_q[PROD_W-1:POS_W]} + (p_q[0] ? {1'b0, a_q} : '0);
	assign rem2 = {rem_q, p_q[63]};
	assign ge   = rem2 >= {1'b0, den_q};
	assign last = (op_q == OP_MUL) ? 6'd47 : 6'd63;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q <= den;
			if (ctl.op == OP_MUL) begin
				p_q <= {{MAG_W{1'b0}}, b};
				a_q <= a;
			end else begin
				rem_q <= p_q[103:64];
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				p_q <= {sum, p_q[POS_W-1:1]};
			end else begin
				rem_q      <= ge ? TIME_W'(rem2 - {1'b0, den_q}) : rem2[TIME_W-1:0];
				p_q[63:0]  <= {p_q[62:0], ge};
			end
		end
	end

	assign done = done_q;
	assign prod = p_q;
endmodule

// ===== hdl/lagrange_window_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// lagrange_window_interpolator_top: Lagrange orbit interpolator over a table
// Loads samples, clears the table, and answers position queries by a
// Lagrange polynomial over a window of order+1 samples around the query.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | req_type, sample_time, sample_x/y/z
//  res     | out | pos_x/y/z, status
//  cfg     | in  | window_order (4 bits)
//
//  Load, clear and ignored requests go from idle straight to the done
//  state and then to the held result. A query runs a binary search for
//  the floor sample, then per window sample k forms its basis weight by
//  multiply and divide in the shared unit and adds its x, y, z products.
//  The request side is not ready while a query runs; one result may wait
//  in the output register while the next word is taken.
//  Reset clears the sample count and sets the order to 8; the table
//  contents are not cleared.
// ----------------------------------------------------------------------------
module lagrange_window_interpolator_top (
	input  logic clk,
	input  logic arst_n,
	lwi_req_if.sink   req,
	lwi_res_if.source res,
	lwi_cfg_if.sink   cfg
);
	import lwi_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] last_time_q;
	logic [ORD_W-1:0]  order_q;
	logic [ORD_W-1:0]  ord_q;
	logic [TIME_W-1:0] t_q;
	logic [ADDR_W-1:0] lo_q, hi_q, st_q;
	logic [ORD_W-1:0]  kk_q;
	logic [ORD_W:0]    ii_q;
	logic [TIME_W-1:0] tk_q;
	logic [TIME_W-1:0] den_q;
	logic [POS_W-1:0]  pos_q [3];
	logic [1:0]        c_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q [3];
	logic [POS_W-1:0]  rx_q, ry_q, rz_q;
	stat_t             rstat_q;
	logic              ov_q;
	logic [POS_W-1:0]  ox_q, oy_q, oz_q;
	stat_t             ostat_q;

	logic              in_acc;
	logic [ORD_W-1:0]  ord_c;
	logic              load_ok;
	stat_t             load_st;
	logic [CNT_W-1:0]  span;
	logic [ADDR_W-1:0] mid;
	logic [ORD_W-1:0]  half;
	logic [CNT_W-1:0]  limit;
	logic [ADDR_W-1:0] st_c;
	logic [TIME_W-1:0] ti, num, den;
	logic              flip;
	logic [POS_W-1:0]  pcur, pmag;
	logic              sneg;
	logic [ACC_W-1:0]  acc_add;
	logic              out_free;
	logic              hi_ovf;
	logic [63:0]       quo;

	alu_ctl_t          alu_ctl;
	logic [POS_W-1:0]  alu_b;
	logic              alu_done;
	logic [PROD_W-1:0] alu_prod;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_data;
	entry_t            wr_data;
	logic              wr_en;

	// Round half up, drop 32 fraction bits, saturate to 48 bits signed.
	function automatic logic [POS_W-1:0] finish(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] s;
		s = acc + (ACC_W'(1) << 31);
		if ((&s[127:79]) || !(|s[127:79])) begin
			return s[79:32];
		end
		return s[127] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	lwi_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lwi_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (mag_q),
		.b      (alu_b),
		.den    (den_q),
		.done   (alu_done),
		.prod   (alu_prod)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc    = req.valid && req.ready;

	// Clamp the order to the supported range.
	assign ord_c = (order_q == '0) ? ORD_W'(1) :
		((order_q > MAX_ORDER) ? MAX_ORDER : order_q);

	assign wr_data = '{t: req.sample_time, x: req.sample_x, y: req.sample_y,
		z: req.sample_z};
	always_comb begin
		load_ok = 1'b0;
		load_st = ST_OK;
		if (count_q >= CNT_W'(MAX_POINTS)) begin
			load_st = ST_FULL;
		end else if (count_q != '0 && req.sample_time <= last_time_q) begin
			load_st = ST_ORDER;
		end else begin
			load_ok = 1'b1;
		end
	end
	assign wr_en = in_acc && (req.req_type == REQ_LOAD) && load_ok;

	// Floor search midpoint, biased up.
	assign span = CNT_W'(hi_q) - CNT_W'(lo_q) + CNT_W'(1);
	assign mid  = lo_q + span[CNT_W-1:1];

	// Window start, clamped to the table.
	assign half  = ord_q >> 1;
	assign limit = count_q - (CNT_W'(ord_q) - CNT_W'(half)) - CNT_W'(1);
	always_comb begin
		if (lo_q < ADDR_W'(half)) begin
			st_c = '0;
		end else if (CNT_W'(lo_q) > limit) begin
			st_c = ADDR_W'(count_q - CNT_W'(ord_q) - CNT_W'(1));
		end else begin
			st_c = lo_q - ADDR_W'(half);
		end
	end

	assign ti   = rd_data.t;
	assign num  = (t_q >= ti) ? t_q - ti : ti - t_q;
	assign den  = (tk_q >= ti) ? tk_q - ti : ti - tk_q;
	assign flip = (t_q < ti) != (tk_q < ti);

	assign pcur    = pos_q[c_q];
	assign pmag    = pcur[POS_W-1] ? POS_W'(0) - pcur : pcur;
	assign sneg    = neg_q ^ pcur[POS_W-1];
	assign acc_add = sneg ? acc_q[c_q] - ACC_W'(alu_prod) : acc_q[c_q] + ACC_W'(alu_prod);
	assign hi_ovf  = alu_prod[PROD_W-1:64] >= (PROD_W-64)'(den_q);
	assign quo     = alu_prod[63:0];
	assign out_free = !ov_q || res.ready;

	// Sequencer: next state, memory read and unit start.
	always_comb begin
		state_d     = state_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		alu_ctl     = '{start: 1'b0, op: OP_MUL};
		alu_b       = pmag;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (req.req_type == REQ_QUERY &&
						count_q >= CNT_W'(ord_c) + CNT_W'(1)) begin
						state_d = S_FIRST;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FIRST: begin
				rd_en   = 1'b1;
				state_d = S_FIRST_W;
			end
			S_FIRST_W: begin
				state_d = (t_q < ti) ? S_START : S_BS;
			end
			S_BS: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					rd_addr = mid;
					state_d = S_BS_W;
				end else begin
					state_d = S_START;
				end
			end
			S_BS_W: state_d = S_BS;
			S_START: state_d = S_K;
			S_K: begin
				rd_en   = 1'b1;
				rd_addr = st_q + ADDR_W'(kk_q);
				state_d = S_K_W;
			end
			S_K_W: state_d = S_I;
			S_I: begin
				if (ii_q > (ORD_W+1)'(ord_q)) begin
					state_d = S_PROD;
				end else if (ii_q != (ORD_W+1)'(kk_q)) begin
					rd_en   = 1'b1;
					rd_addr = st_q + ADDR_W'(ii_q);
					state_d = S_I_W;
				end
			end
			S_I_W: begin
				if (mag_q == '0 || num == '0) begin
					state_d = S_I;
				end else begin
					alu_ctl = '{start: 1'b1, op: OP_MUL};
					alu_b   = POS_W'(num);
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (alu_done) begin
					if (hi_ovf) begin
						state_d = S_I;
					end else begin
						alu_ctl = '{start: 1'b1, op: OP_DIV};
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (alu_done) begin
					state_d = S_I;
				end
			end
			S_PROD: begin
				alu_ctl = '{start: 1'b1, op: OP_MUL};
				state_d = S_PMUL;
			end
			S_PMUL: begin
				if (alu_done) begin
					if (c_q != 2'd2) begin
						state_d = S_PROD;
					end else if (kk_q == ord_q) begin
						state_d = S_FIN;
					end else begin
						state_d = S_K;
					end
				end
			end
			S_FIN: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			order_q <= ORDER_RST;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				order_q <= cfg.data;
			end
			if (in_acc) begin
				if (req.req_type == REQ_CLEAR) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			// Hold the result until taken; refill when the register frees up.
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					t_q     <= req.sample_time;
					ord_q   <= ord_c;
					lo_q    <= '0;
					hi_q    <= ADDR_W'(count_q - CNT_W'(1));
					rx_q    <= '0;
					ry_q    <= '0;
					rz_q    <= '0;
					rstat_q <= ST_OK;
					if (req.req_type == REQ_LOAD) begin
						rstat_q <= load_st;
						if (load_ok) begin
							last_time_q <= req.sample_time;
						end
					end else if (req.req_type == REQ_QUERY &&
						count_q < CNT_W'(ord_c) + CNT_W'(1)) begin
						rstat_q <= ST_FEW;
					end
				end
			end
			S_BS_W: begin
				if (ti <= t_q) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid - ADDR_W'(1);
				end
			end
			S_START: begin
				st_q     <= st_c;
				kk_q     <= '0;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
			end
			S_K_W: begin
				tk_q     <= rd_data.t;
				pos_q[0] <= rd_data.x;
				pos_q[1] <= rd_data.y;
				pos_q[2] <= rd_data.z;
				mag_q    <= W_ONE;
				neg_q    <= 1'b0;
				ii_q     <= '0;
				c_q      <= '0;
			end
			S_I: begin
				if (ii_q == (ORD_W+1)'(kk_q)) begin
					ii_q <= ii_q + (ORD_W+1)'(1);
				end
			end
			S_I_W: begin
				den_q <= den;
				neg_q <= neg_q ^ flip;
				if (mag_q == '0 || num == '0) begin
					mag_q <= '0;
					ii_q  <= ii_q + (ORD_W+1)'(1);
				end
			end
			S_MUL: begin
				if (alu_done && hi_ovf) begin
					mag_q <= W_MAX;
					ii_q  <= ii_q + (ORD_W+1)'(1);
				end
			end
			S_DIV: begin
				if (alu_done) begin
					mag_q <= (quo > 64'(W_MAX)) ? W_MAX : quo[MAG_W-1:0];
					ii_q  <= ii_q + (ORD_W+1)'(1);
				end
			end
			S_PMUL: begin
				if (alu_done) begin
					acc_q[c_q] <= acc_add;
					c_q        <= c_q + 2'd1;
					if (c_q == 2'd2) begin
						kk_q <= kk_q + ORD_W'(1);
					end
				end
			end
			S_FIN: begin
				rx_q <= finish(acc_q[0]);
				ry_q <= finish(acc_q[1]);
				rz_q <= finish(acc_q[2]);
			end
			S_DONE: begin
				if (out_free) begin
					ox_q    <= rx_q;
					oy_q    <= ry_q;
					oz_q    <= rz_q;
					ostat_q <= rstat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid  = ov_q;
	assign res.pos_x  = ox_q;
	assign res.pos_y  = oy_q;
	assign res.pos_z  = oz_q;
	assign res.status = ostat_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("sample count above table depth");
	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_I || state_q == S_PROD) |-> mag_q <= W_MAX)
		else $error("basis weight above saturation");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_K) |-> kk_q <= ord_q)
		else $error("window index past order");
	a_div_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> den_q != '0)
		else $error("divide started with zero divisor");
`endif
endmodule

// ===== test/lagrange_window_checker.sv =====
// ----------------------------------------------------------------------------
// lagrange_window_checker: position predictor and result scoreboard
// Watches the request, result and order channels, keeps its own sample table
// and window order, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module lagrange_window_checker
	import lwi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lwi_req_if   req,
	lwi_res_if   res,
	lwi_cfg_if   cfg,
	output int   fail_count,
	output int   open_count
);

	typedef struct {
		logic [47:0] x;
		logic [47:0] y;
		logic [47:0] z;
		stat_t       status;
	} fix_t;

	localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF;
	localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

	logic [39:0] t_tab [MAX_POINTS];
	logic [47:0] x_tab [MAX_POINTS];
	logic [47:0] y_tab [MAX_POINTS];
	logic [47:0] z_tab [MAX_POINTS];
	int          n_pts;
	logic [3:0]  win_ord;
	fix_t        pos_due [$];

	initial begin
		fail_count = 0;
		open_count = 0;
		n_pts      = 0;
		win_ord    = ORDER_RST;
	end

	// floor(w * num / den), saturated
	function automatic logic [62:0] scale_weight(logic [62:0] w, logic [39:0] num,
		logic [39:0] den);
		logic [127:0] q;
		if (w == 0 || num == 0) return '0;
		if (den == 0) return W_MAX;
		q = (128'(w) * 128'(num)) / 128'(den);
		return (q > 128'(W_MAX)) ? W_MAX : q[62:0];
	endfunction

	function automatic logic [47:0] round_sat(logic signed [127:0] s);
		logic signed [127:0] r;
		r = (s + 128'sd2147483648) >>> 32;
		if (r > SAT_HI) return SAT_HI[47:0];
		if (r < SAT_LO) return SAT_LO[47:0];
		return r[47:0];
	endfunction

	task automatic interpolate(input logic [39:0] t, output fix_t f);
		logic signed [127:0] acc [3];
		logic [47:0]  p;
		logic [48:0]  pmag;
		logic [127:0] prod;
		logic [62:0]  mag;
		logic         neg;
		logic [39:0]  tk, ti, num, den;
		int           ord, half, idx, st;
		f.x = '0;
		f.y = '0;
		f.z = '0;
		f.status = ST_OK;
		ord = (win_ord == 0) ? 1 : int'(win_ord);
		if (n_pts < ord + 1) begin
			f.status = ST_FEW;
			return;
		end
		half = ord / 2;
		idx = 0;
		for (int i = 0; i < n_pts; i++)
			if (t_tab[i] <= t) idx = i;
		if (idx < half) st = 0;
		else if (idx > n_pts - (ord - half) - 1) st = n_pts - ord - 1;
		else st = idx - half;
		for (int c = 0; c < 3; c++) acc[c] = '0;
		for (int k = st; k <= st + ord; k++) begin
			mag = W_ONE;
			neg = 1'b0;
			tk = t_tab[k];
			for (int i = st; i <= st + ord; i++) begin
				if (i != k) begin
					ti = t_tab[i];
					num = (t >= ti) ? t - ti : ti - t;
					den = (tk >= ti) ? tk - ti : ti - tk;
					mag = scale_weight(mag, num, den);
					neg = neg ^ ((t < ti) != (tk < ti));
				end
			end
			for (int c = 0; c < 3; c++) begin
				p = (c == 0) ? x_tab[k] : (c == 1) ? y_tab[k] : z_tab[k];
				pmag = p[47] ? (49'h1_0000_0000_0000 - {1'b0, p}) : {1'b0, p};
				prod = 128'(mag) * 128'(pmag);
				if (neg != p[47]) prod = -prod;
				acc[c] = acc[c] + signed'(prod);
			end
		end
		f.x = round_sat(acc[0]);
		f.y = round_sat(acc[1]);
		f.z = round_sat(acc[2]);
	endtask

	task automatic predict_word(output fix_t f);
		f.x = '0;
		f.y = '0;
		f.z = '0;
		f.status = ST_OK;
		case (req.req_type)
			REQ_LOAD: begin
				if (n_pts >= MAX_POINTS) f.status = ST_FULL;
				else if (n_pts > 0 && req.sample_time <= t_tab[n_pts-1]) f.status = ST_ORDER;
				else begin
					t_tab[n_pts] = req.sample_time;
					x_tab[n_pts] = req.sample_x;
					y_tab[n_pts] = req.sample_y;
					z_tab[n_pts] = req.sample_z;
					n_pts++;
				end
			end
			REQ_CLEAR: n_pts = 0;
			REQ_QUERY: interpolate(req.sample_time, f);
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		fix_t want, got;
		if (!arst_n) begin
			n_pts = 0;
			win_ord = ORDER_RST;
			pos_due.delete();
			open_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) win_ord = cfg.data;
			if (res.valid && res.ready) begin
				got.x = res.pos_x;
				got.y = res.pos_y;
				got.z = res.pos_z;
				got.status = stat_t'(res.status);
				if (pos_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: x=%h y=%h z=%h status=%0d",
							got.x, got.y, got.z, got.status);
				end else begin
					want = pos_due.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z
						|| got.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
								want.x, want.y, want.z, want.status,
								got.x, got.y, got.z, got.status);
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_word(want);
				pos_due.push_back(want);
			end
			open_count = pos_due.size();
		end
	end

endmodule

// ===== test/tb_lagrange_window_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// tb_lagrange_window_interpolator_top: stimulus and verdict for the interpolator
// Directed loads, clears and queries at the reset order, then random phases
// over several window orders, then a fill to a full table and a last part with no idling. The checker
// predicts and compares; this module drives the channels and reports.
// ----------------------------------------------------------------------------
module tb_lagrange_window_interpolator_top;
	import lwi_pkg::*;

	// an order-15 query runs long with no word moving; leave wide margin
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [47:0] MIN48 = 48'h8000_0000_0000;
	localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errs;
	int   pend;
	int   stall = 0;
	bit   calm = 1'b0;      // no idling on either side while set
	bit   hold_res = 1'b0;  // request one long result hold-off

	// stimulus-side view of the table, used to shape well-formed loads and query times
	int          n_loaded = 0;
	logic [39:0] first_t = '0;
	logic [39:0] last_t = '0;

	lwi_req_if req_ch();
	lwi_res_if res_ch();
	lwi_cfg_if cfg_ch();

	always #1 clk = ~clk;

	lagrange_window_interpolator_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	lagrange_window_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg       (cfg_ch),
		.fail_count(errs),
		.open_count(pend)
	);

	// Watchdog: end the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			stall <= 0;
		end else begin
			stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result side: short random stalls, or one long hold-off on request so the
	// output register fills and the request side backs up.
	initial begin
		res_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_res) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_res = 1'b0;
				res_ch.ready = 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				res_ch.ready = 1'b1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[47:0];
	endfunction

	function automatic logic [39:0] rand40();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[39:0];
	endfunction

	// Offer one request word, hold it until accepted, advance to the next
	// falling edge. Valid stays high so back-to-back words need no gap.
	task automatic push_word(req_t r, logic [39:0] t, logic [47:0] x, logic [47:0] y,
		logic [47:0] z);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.req_type    = r;
		req_ch.sample_time = t;
		req_ch.sample_x    = x;
		req_ch.sample_y    = y;
		req_ch.sample_z    = z;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (r == REQ_LOAD && n_loaded < MAX_POINTS && (n_loaded == 0 || t > last_t)) begin
			if (n_loaded == 0) first_t = t;
			last_t = t;
			n_loaded++;
		end
		if (r == REQ_CLEAR) n_loaded = 0;
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic drain();
		req_ch.valid = 1'b0;
		while (pend != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic set_order(int o);
		drain();
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = o[3:0];
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Load a sample after the last one, clamped to MAX40; the step spans many scales.
	task automatic load_next(int max_bits);
		logic [63:0] t;
		logic [63:0] step;
		step = {$urandom(), $urandom()} & ((64'd1 << $urandom_range(0, max_bits)) - 1);
		if (n_loaded == 0) t = {$urandom(), $urandom()} & 64'h7F_FFFF_FFFF;
		else t = 64'(last_t) + step + 1;
		if (t > 64'(MAX40)) t = 64'(MAX40);
		push_word(REQ_LOAD, t[39:0], rand48(), rand48(), rand48());
	endtask

	// Query time mostly inside the loaded span, with a margin on each side.
	function automatic logic [39:0] query_time();
		logic [63:0] lo, hi, m, v;
		if (n_loaded == 0) return rand40();
		m  = (64'(last_t) - 64'(first_t)) / 8 + 1;
		lo = (64'(first_t) > m) ? 64'(first_t) - m : 64'd0;
		hi = 64'(last_t) + m;
		if (hi > 64'(MAX40)) hi = 64'(MAX40);
		v = {$urandom(), $urandom()};
		v = lo + v % (hi - lo + 1);
		return v[39:0];
	endfunction

	task automatic run_phase(int o, int loads, int queries);
		int r;
		set_order(o);
		calm = ($urandom_range(0, 3) == 0);
		push_word(REQ_CLEAR, rand40(), rand48(), rand48(), rand48());
		while (loads > 0 || queries > 0) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// noise: stale load, ignored type, query anywhere in time
				case ($urandom_range(0, 2))
					0: push_word(REQ_LOAD, (n_loaded > 0) ? last_t - $urandom_range(0, 3)
						: rand40(), rand48(), rand48(), rand48());
					1: push_word(REQ_NONE, rand40(), rand48(), rand48(), rand48());
					default: push_word(REQ_QUERY, rand40(), rand48(), rand48(), rand48());
				endcase
			end else if (loads > 0 && (queries == 0 || n_loaded < o + 2 || r < 55)) begin
				load_next(34);
				loads--;
			end else begin
				push_word(REQ_QUERY, query_time(), rand48(), rand48(), rand48());
				queries--;
			end
		end
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_NONE;
		req_ch.sample_time = '0;
		req_ch.sample_x    = '0;
		req_ch.sample_y    = '0;
		req_ch.sample_z    = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset order of 8.
		push_word(REQ_QUERY, '0, '0, '0, '0);                 // empty table: too few
		push_word(REQ_NONE, MAX40, MAX48, MIN48, '1);         // ignored request type
		push_word(REQ_CLEAR, '0, '0, '0, '0);
		push_word(REQ_LOAD, 40'd5, MIN48, MAX48, '1);         // position extremes
		push_word(REQ_LOAD, 40'd0, '0, '0, '0);               // earlier time: rejected
		push_word(REQ_LOAD, 40'd5, '0, '0, '0);               // equal time: rejected
		for (int k = 1; k <= 8; k++)
			push_word(REQ_LOAD, 40'd5 + 40'(k * k) * 40'd70000,
				(k % 2 == 1) ? MAX48 : MIN48, rand48(), 48'(k * 1000));
		push_word(REQ_QUERY, 40'd0, '0, '0, '0);              // before the first sample
		push_word(REQ_QUERY, 40'd280005, '0, '0, '0);         // exactly on a sample
		push_word(REQ_QUERY, 40'd20005, '0, '0, '0);          // between samples
		push_word(REQ_QUERY, 40'd2000000, '0, '0, '0);        // between later samples
		push_word(REQ_QUERY, MAX40, '0, '0, '0);              // latest possible time

		// Random phases over the order range; large orders get few queries.
		run_phase(0, 14, 15);
		run_phase(1, 14, 15);
		run_phase(2, 16, 15);
		run_phase(3, 16, 12);
		run_phase(4, 18, 6);
		run_phase(6, 18, 5);
		run_phase(15, 20, 3);
		run_phase(7, 18, 4);

		// Fill the table at order 1 with a long result hold-off at the start.
		set_order(1);
		calm = 1'b0;
		push_word(REQ_CLEAR, '0, '0, '0, '0);
		push_word(REQ_LOAD, 40'($urandom_range(0, 1000)), rand48(), rand48(), rand48());
		hold_res = 1'b1;
		while (n_loaded < MAX_POINTS) begin
			if ($urandom_range(0, 24) == 0)
				push_word(REQ_QUERY, query_time(), rand48(), rand48(), rand48());
			else
				load_next(28);
		end

		// Last part: no idling on either side.
		calm = 1'b1;
		push_word(REQ_LOAD, MAX40, rand48(), rand48(), rand48());  // table full
		push_word(REQ_LOAD, MAX40, rand48(), rand48(), rand48());
		push_word(REQ_QUERY, MAX40, '0, '0, '0);
		push_word(REQ_QUERY, '0, '0, '0, '0);
		repeat (10) push_word(REQ_QUERY, query_time(), rand48(), rand48(), rand48());
		push_word(REQ_CLEAR, rand40(), rand48(), rand48(), rand48());
		push_word(REQ_LOAD, rand40(), rand48(), rand48(), rand48());
		push_word(REQ_QUERY, rand40(), '0, '0, '0);           // one sample: too few

		drain();
		repeat (20) @(posedge clk);
		if (errs == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
